// File: rtl/core/bmsirq_pkg.sv
// Shared constants for the bank mapper with scanline interrupt counter.
package bmsirq_pkg;

    // Default width of the program bank outputs
    localparam int PRG_BANK_BITS_DEFAULT = 6;

    // Width used for the fixed-bank arithmetic (covers the widest bank number)
    localparam int BANK_CALC_W = 8;

    // Item function codes
    localparam logic [1:0] FUNC_WRITE      = 2'd0;
    localparam logic [1:0] FUNC_TICK       = 2'd1;
    localparam logic [1:0] FUNC_SOFT_RESET = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROM_BANK_COUNT   = 2'd0;
    localparam logic [1:0] CFG_CHR_IN_RAM       = 2'd1;
    localparam logic [1:0] CFG_HEADER_MIRRORING = 2'd2;

    // Configuration reset values
    localparam logic [6:0] ROM_BANK_COUNT_RESET = 7'd32;

    // Register write address decode
    localparam logic [15:0] ADDR_MASK        = 16'hE001;
    localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] ADDR_MIRRORING   = 16'hA000;
    localparam logic [15:0] ADDR_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;

    // Data masks and bank select flags
    localparam logic [7:0] CHR_PAIR_MASK   = 8'hFE;
    localparam int         SEL_PRG_SWAP    = 6;
    localparam int         SEL_CHR_SWAP    = 7;

    // Last scanline on which the counter runs
    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

    // Mirroring output code for four-screen
    localparam logic [1:0] MIRRORING_QUAD = 2'd2;

    // Character bank reset values for ROM; RAM resets to zero on a soft reset
    localparam int CHR_REG_COUNT = 6;
    localparam logic [7:0] CHR_ROM_INIT [CHR_REG_COUNT] =
        '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};

    // Program bank reset values
    localparam logic [7:0] PRG0_INIT = 8'd0;
    localparam logic [7:0] PRG1_INIT = 8'd1;

endpackage

// File: rtl/core/bank_mapper_scanline_irq_unit.sv
// Bank mapper with scanline interrupt counter: decode, counter and result register.
// Each result is registered in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while in_stall is low; state update and map build
// sit in one stage between the input ports and the result register.
// in_stall rises only while a finished result waits with out_stall high.
// Reset (rst_n, asynchronous): configuration to its defaults, bank and IRQ
// state to power-up values, no result pending.
module bank_mapper_scanline_irq_unit #(
    parameter int PRG_BANK_BITS = bmsirq_pkg::PRG_BANK_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [6:0]               cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [15:0]              addr,
    input  logic [7:0]               data,
    input  logic [8:0]               scanline,
    input  logic                     rendering_enabled,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     irq_pulse,
    output logic [PRG_BANK_BITS-1:0] prg_bank_8000,
    output logic [PRG_BANK_BITS-1:0] prg_bank_a000,
    output logic [PRG_BANK_BITS-1:0] prg_bank_c000,
    output logic [PRG_BANK_BITS-1:0] prg_bank_e000,
    output logic [63:0]              chr_slots,
    output logic [1:0]               mirroring
);

    localparam int ChrN  = bmsirq_pkg::CHR_REG_COUNT;
    localparam int CalcW = bmsirq_pkg::BANK_CALC_W;

    // Configuration registers
    logic [6:0] rom_bank_count_reg;
    logic       chr_in_ram_reg;
    logic [1:0] header_mirroring_reg;

    // Mapper state
    logic [7:0] bank_select_reg, bank_select_next;
    logic [7:0] prg_reg      [2];
    logic [7:0] prg_next     [2];
    logic [7:0] chr_reg      [ChrN];
    logic [7:0] chr_next     [ChrN];
    logic       mirror_state_reg, mirror_state_next;
    logic [7:0] irq_latch_reg, irq_latch_next;
    logic [7:0] irq_count_reg, irq_count_next;
    logic       reload_pending_reg, reload_pending_next;
    logic       irq_on_reg, irq_on_next;
    logic       fire;

    // Result register
    logic                     out_valid_reg;
    logic                     irq_pulse_reg;
    logic [PRG_BANK_BITS-1:0] prg_8000_reg, prg_a000_reg, prg_c000_reg, prg_e000_reg;
    logic [PRG_BANK_BITS-1:0] prg_8000_next, prg_c000_next;
    logic [63:0]              chr_slots_reg, chr_slots_next;
    logic [1:0]               mirroring_reg, mirroring_next;

    logic                     in_accept;
    logic [CalcW-1:0]         bank_last, bank_second;
    logic [15:0]              addr_dec;
    logic [2:0]               sel;
    logic                     tick_active;
    logic [31:0]              chr_lo, chr_hi;
    logic [7:0]               chr0_odd, chr1_odd;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign addr_dec    = addr & bmsirq_pkg::ADDR_MASK;
    assign sel         = bank_select_reg[2:0];
    assign tick_active = (scanline <= bmsirq_pkg::LAST_VISIBLE_LINE) & rendering_enabled;

    // Apply the transaction to the mapper state
    always_comb
    begin
        bank_select_next    = bank_select_reg;
        prg_next            = prg_reg;
        chr_next            = chr_reg;
        mirror_state_next   = mirror_state_reg;
        irq_latch_next      = irq_latch_reg;
        irq_count_next      = irq_count_reg;
        reload_pending_next = reload_pending_reg;
        irq_on_next         = irq_on_reg;
        fire                = 1'b0;
        case (func)
            bmsirq_pkg::FUNC_WRITE:
            begin
                unique case (addr_dec)
                    bmsirq_pkg::ADDR_BANK_SELECT: bank_select_next = data;
                    bmsirq_pkg::ADDR_BANK_DATA:
                    begin
                        if (sel < 3'd2)
                            chr_next[sel] = data & bmsirq_pkg::CHR_PAIR_MASK;
                        else if (sel < 3'd6)
                            chr_next[sel] = data;
                        else
                            prg_next[sel[0]] = data;
                    end
                    bmsirq_pkg::ADDR_MIRRORING:
                    begin
                        if (!header_mirroring_reg[1])
                            mirror_state_next = data[0];
                    end
                    bmsirq_pkg::ADDR_IRQ_LATCH:   irq_latch_next      = data;
                    bmsirq_pkg::ADDR_IRQ_RELOAD:  reload_pending_next = 1'b1;
                    bmsirq_pkg::ADDR_IRQ_DISABLE: irq_on_next         = 1'b0;
                    bmsirq_pkg::ADDR_IRQ_ENABLE:  irq_on_next         = 1'b1;
                    default: ;
                endcase
            end
            bmsirq_pkg::FUNC_TICK:
            begin
                if (tick_active)
                begin
                    irq_count_next = irq_count_reg - 8'd1;
                    if (irq_count_reg == 8'd0)
                    begin
                        irq_count_next = irq_latch_reg;
                        fire           = irq_on_reg;
                    end
                    if (reload_pending_reg)
                    begin
                        irq_count_next      = irq_latch_reg;
                        reload_pending_next = 1'b0;
                    end
                end
            end
            bmsirq_pkg::FUNC_SOFT_RESET:
            begin
                bank_select_next = '0;
                prg_next[0]      = bmsirq_pkg::PRG0_INIT;
                prg_next[1]      = bmsirq_pkg::PRG1_INIT;
                for (int i = 0; i < ChrN; i++)
                    chr_next[i] = chr_in_ram_reg ? 8'd0 : bmsirq_pkg::CHR_ROM_INIT[i];
                irq_latch_next      = '0;
                irq_count_next      = '0;
                reload_pending_next = 1'b0;
                irq_on_next         = 1'b0;
            end
            default: ;
        endcase
    end

    // Build the bank map from the updated state
    assign bank_last   = {1'b0, rom_bank_count_reg} - CalcW'(1);
    assign bank_second = {1'b0, rom_bank_count_reg} - CalcW'(2);

    always_comb
    begin
        if (bank_select_next[bmsirq_pkg::SEL_PRG_SWAP])
        begin
            prg_8000_next = bank_second[PRG_BANK_BITS-1:0];
            prg_c000_next = prg_next[0][PRG_BANK_BITS-1:0];
        end
        else
        begin
            prg_8000_next = prg_next[0][PRG_BANK_BITS-1:0];
            prg_c000_next = bank_second[PRG_BANK_BITS-1:0];
        end
    end

    assign chr0_odd = chr_next[0] + 8'd1;
    assign chr1_odd = chr_next[1] + 8'd1;
    assign chr_lo   = {chr1_odd, chr_next[1], chr0_odd, chr_next[0]};
    assign chr_hi   = {chr_next[5], chr_next[4], chr_next[3], chr_next[2]};

    // Exchange the two halves when the character swap flag is set
    assign chr_slots_next = bank_select_next[bmsirq_pkg::SEL_CHR_SWAP] ?
                            {chr_lo, chr_hi} : {chr_hi, chr_lo};
    assign mirroring_next = header_mirroring_reg[1] ? bmsirq_pkg::MIRRORING_QUAD :
                            {1'b0, mirror_state_next};

    // Hold configuration and mapper state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg   <= bmsirq_pkg::ROM_BANK_COUNT_RESET;
            chr_in_ram_reg       <= 1'b0;
            header_mirroring_reg <= '0;
            bank_select_reg      <= '0;
            prg_reg[0]           <= bmsirq_pkg::PRG0_INIT;
            prg_reg[1]           <= bmsirq_pkg::PRG1_INIT;
            for (int i = 0; i < ChrN; i++)
                chr_reg[i] <= bmsirq_pkg::CHR_ROM_INIT[i];
            mirror_state_reg     <= 1'b0;
            irq_latch_reg        <= '0;
            irq_count_reg        <= '0;
            reload_pending_reg   <= 1'b0;
            irq_on_reg           <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bmsirq_pkg::CFG_ROM_BANK_COUNT:   rom_bank_count_reg   <= cfg_data;
                    bmsirq_pkg::CFG_CHR_IN_RAM:       chr_in_ram_reg       <= cfg_data[0];
                    bmsirq_pkg::CFG_HEADER_MIRRORING: header_mirroring_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            // A header write reloads the mirroring, else follow the transaction
            if (cfg_valid && cfg_ready && cfg_index == bmsirq_pkg::CFG_HEADER_MIRRORING)
                mirror_state_reg <= cfg_data[0];
            else if (in_accept)
                mirror_state_reg <= mirror_state_next;
            if (in_accept)
            begin
                bank_select_reg    <= bank_select_next;
                prg_reg            <= prg_next;
                chr_reg            <= chr_next;
                irq_latch_reg      <= irq_latch_next;
                irq_count_reg      <= irq_count_next;
                reload_pending_reg <= reload_pending_next;
                irq_on_reg         <= irq_on_next;
            end
            // Advance the result valid flag
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result register on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            irq_pulse_reg <= fire;
            prg_8000_reg  <= prg_8000_next;
            prg_a000_reg  <= prg_next[1][PRG_BANK_BITS-1:0];
            prg_c000_reg  <= prg_c000_next;
            prg_e000_reg  <= bank_last[PRG_BANK_BITS-1:0];
            chr_slots_reg <= chr_slots_next;
            mirroring_reg <= mirroring_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign irq_pulse     = irq_pulse_reg;
    assign prg_bank_8000 = prg_8000_reg;
    assign prg_bank_a000 = prg_a000_reg;
    assign prg_bank_c000 = prg_c000_reg;
    assign prg_bank_e000 = prg_e000_reg;
    assign chr_slots     = chr_slots_reg;
    assign mirroring     = mirroring_reg;

`ifndef SYNTHESIS
    // A stall on the input side only ever comes from a waiting result
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // Every accepted transaction leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted transaction produced no result");

    // Only a scanline tick can raise the interrupt pulse
    a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func != bmsirq_pkg::FUNC_TICK) |=> !irq_pulse)
        else $error("interrupt pulse on a non-tick transaction");

    // The pulse needs the interrupt enabled beforehand
    a_pulse_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !irq_on_reg) |=> !irq_pulse)
        else $error("interrupt pulse while disabled");

    // Soft reset drops interrupt enable and any pending reload
    a_soft_reset_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func == bmsirq_pkg::FUNC_SOFT_RESET)
        |=> (!irq_on_reg && !reload_pending_reg && irq_count_reg == 8'd0))
        else $error("soft reset left interrupt state behind");
`endif

endmodule
